// File: sv/lso_pkg.sv
// shared types, constants and cosine table for the leader speed observer
package lso_pkg;

	localparam int COS_TABLE_BITS = 8;
	localparam int COS_N = 1 << COS_TABLE_BITS;

	localparam logic signed [23:0] GAIN_RESET = -24'sd144179;
	localparam logic [22:0] OUT_MAX = 23'h7FFFFF;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ERR,
		S_MK,
		S_MC,
		S_MH,
		S_ML,
		S_EST,
		S_OUT
	} state_t;

	typedef logic [16:0] cos_table_t [COS_N];

	// taylor coefficients of the quarter-wave cosine, q30
	typedef longint unsigned coef_t [6];
	localparam coef_t COS_COEF = '{
		64'd1073741824, 64'd1324675879, 64'd272375560,
		64'd22401992, 64'd987048, 64'd27060
	};

	// quarter-wave entry k in q16, horner evaluation in q30
	function automatic logic [16:0] cos_entry(input int k);
		longint unsigned q;
		longint unsigned u;
		longint unsigned p;
		longint unsigned t;
		longint unsigned r;
		q = longint'(k) << (16 - COS_TABLE_BITS);
		u = (q * q) >> 2;
		p = COS_COEF[5];
		for (int i = 4; i >= 0; i--) begin
			t = (p * u) >> 30;
			p = (COS_COEF[i] > t) ? COS_COEF[i] - t : 64'd0;
		end
		r = (p + 64'd8192) >> 14;
		return r[16:0];
	endfunction

	function automatic cos_table_t cos_table_build();
		cos_table_t tab;
		for (int k = 0; k < COS_N; k++) begin
			tab[k] = cos_entry(k);
		end
		return tab;
	endfunction

	localparam cos_table_t COS_TABLE = cos_table_build();
	// entry for a phase of exactly a quarter turn
	localparam logic [16:0] COS_LAST = cos_entry(COS_N);

endpackage

// File: sv/leader_speed_observer.sv
// leader speed observer: iterative fixed-point observer around one shared multiplier
//
// item channel: item_valid / item_stall with command, step_time, gap_deviation,
// heading_error and own_speed. a transaction completes on a clock edge with
// item_valid high and item_stall low. item_stall is high whenever an item is
// being worked on, so one item is handled at a time.
// result channel: result_valid / result_stall with leader_speed_estimate, one
// result per item, held in an output register until taken.
// gain register: written on any edge with gain_wen high; the user must write it
// only while idle, as the block itself does not enforce this. a reset command or
// the first update after reset goes from acceptance straight to the output state;
// a normal update passes through error, four multiplier passes (gain*error,
// speed*cos, step_time*correction in two halves) and the estimate update first.
// a new item is taken only once the last result has left the sequencer, and the
// single 34x25 multiplier is reused for every product.
// if the receiver stalls, the finished result waits in the sequencer until
// the output register frees, and no new item is taken meanwhile.
// reset (arst_n low) clears the initialised flag and deviation estimate,
// restores the default gain and empties the output register.
module leader_speed_observer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        gain_wen,
	input  logic [23:0] gain_wdata,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        command,
	input  logic [15:0] step_time,
	input  logic [23:0] gap_deviation,
	input  logic [15:0] heading_error,
	input  logic [23:0] own_speed,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [22:0] leader_speed_estimate
);

	lso_pkg::state_t state_q, state_d;

	logic signed [23:0] gain_q;
	logic signed [31:0] est_q;
	logic               init_q;

	logic [15:0]        dt_q;
	logic signed [23:0] gap_q;
	logic [15:0]        angle_q;
	logic signed [23:0] speed_q;

	logic signed [32:0] err_q;
	logic signed [17:0] cos_q;
	logic signed [58:0] mul_q;
	logic signed [40:0] corr_q;
	logic signed [41:0] leader_q;
	logic signed [57:0] acc_q;
	logic [22:0]        res_q;
	logic               result_valid_q;
	logic [22:0]        result_q;

	logic               accept;
	logic               out_free;
	logic signed [33:0] mul_a;
	logic signed [24:0] mul_b;

	// cosine lookup
	logic [1:0]                      quad;
	logic [lso_pkg::COS_TABLE_BITS:0] k_idx;
	logic [lso_pkg::COS_TABLE_BITS:0] t_idx;
	logic [16:0]                     cos_mag;
	logic                            cos_neg;

	// rounding and update arithmetic
	logic signed [58:0] mul_rnd;
	logic signed [57:0] dt_sum;
	logic signed [57:0] dt_rnd;
	logic signed [41:0] delta;
	logic signed [42:0] est_sum;
	logic signed [31:0] est_sat;
	logic [22:0]        leader_clamp;

	assign accept   = item_valid && !item_stall;
	assign out_free = !result_valid_q || !result_stall;

	assign quad    = angle_q[15:14];
	assign k_idx   = {1'b0, angle_q[13 -: lso_pkg::COS_TABLE_BITS]};
	assign t_idx   = quad[0] ? ((lso_pkg::COS_TABLE_BITS + 1)'(lso_pkg::COS_N) - k_idx) : k_idx;
	assign cos_mag = t_idx[lso_pkg::COS_TABLE_BITS] ? lso_pkg::COS_LAST
	                 : lso_pkg::COS_TABLE[t_idx[lso_pkg::COS_TABLE_BITS-1:0]];
	assign cos_neg = quad[0] ^ quad[1];

	assign mul_rnd = mul_q + 59'sd32768;
	assign dt_sum  = acc_q + mul_q[57:0];
	assign dt_rnd  = dt_sum + 58'sd32768;
	assign delta   = dt_rnd[57:16];
	assign est_sum = 43'(est_q) + 43'(delta);

	always_comb begin
		if (est_sum > 43'sd2147483647) begin
			est_sat = 32'sh7FFFFFFF;
		end else if (est_sum < -43'sd2147483648) begin
			est_sat = 32'sh80000000;
		end else begin
			est_sat = est_sum[31:0];
		end
	end

	always_comb begin
		if (leader_q < 42'sd0) begin
			leader_clamp = '0;
		end else if (leader_q > 42'($unsigned(lso_pkg::OUT_MAX))) begin
			leader_clamp = lso_pkg::OUT_MAX;
		end else begin
			leader_clamp = leader_q[22:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lso_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (command || !init_q) ? lso_pkg::S_OUT : lso_pkg::S_ERR;
				end
			end
			lso_pkg::S_ERR: state_d = lso_pkg::S_MK;
			lso_pkg::S_MK:  state_d = lso_pkg::S_MC;
			lso_pkg::S_MC:  state_d = lso_pkg::S_MH;
			lso_pkg::S_MH:  state_d = lso_pkg::S_ML;
			lso_pkg::S_ML:  state_d = lso_pkg::S_EST;
			lso_pkg::S_EST: state_d = lso_pkg::S_OUT;
			lso_pkg::S_OUT: begin
				if (out_free) begin
					state_d = lso_pkg::S_IDLE;
				end
			end
			default: state_d = lso_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs: handshake and multiplier operand selection
	always_comb begin
		item_stall = (state_q != lso_pkg::S_IDLE);
		mul_a      = '0;
		mul_b      = '0;
		unique case (state_q)
			lso_pkg::S_MK: begin
				mul_a = 34'(err_q);
				mul_b = 25'(gain_q);
			end
			lso_pkg::S_MC: begin
				mul_a = 34'(speed_q);
				mul_b = 25'(cos_q);
			end
			lso_pkg::S_MH: begin
				mul_a = 34'($signed(corr_q[40:20]));
				mul_b = $signed({9'b0, dt_q});
			end
			lso_pkg::S_ML: begin
				mul_a = $signed({14'b0, corr_q[19:0]});
				mul_b = $signed({9'b0, dt_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= lso_pkg::S_IDLE;
			gain_q         <= lso_pkg::GAIN_RESET;
			est_q          <= '0;
			init_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (gain_wen) begin
				gain_q <= gain_wdata;
			end
			if (accept) begin
				if (command) begin
					init_q <= 1'b0;
				end else if (!init_q) begin
					est_q  <= 32'(signed'(gap_deviation));
					init_q <= 1'b1;
				end
			end
			if (state_q == lso_pkg::S_EST) begin
				est_q <= est_sat;
			end
			if (state_q == lso_pkg::S_OUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			dt_q    <= step_time;
			gap_q   <= gap_deviation;
			angle_q <= heading_error;
			speed_q <= own_speed;
			res_q   <= '0;
		end
		mul_q <= mul_a * mul_b;
		unique case (state_q)
			lso_pkg::S_ERR: begin
				err_q <= 33'(est_q) - 33'(gap_q);
				cos_q <= cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
			end
			lso_pkg::S_MC: corr_q <= mul_rnd[56:16];
			lso_pkg::S_MH: leader_q <= 42'(corr_q) + 42'($signed(mul_rnd[40:16]));
			lso_pkg::S_ML: acc_q <= {mul_q[37:0], 20'b0};
			lso_pkg::S_EST: res_q <= leader_clamp;
			default: ;
		endcase
		if (state_q == lso_pkg::S_OUT && out_free) begin
			result_q <= res_q;
		end
	end

	assign result_valid          = result_valid_q;
	assign leader_speed_estimate = result_q;

endmodule

// File: test/leader_speed_observer_tb.sv
// self-checking testbench for the leader speed observer
module leader_speed_observer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_RESET  = 1'b1;

	localparam logic [23:0] GAIN_MAX  = 24'h7FFFFF;
	localparam logic [23:0] GAIN_MIN  = 24'h800000;
	localparam logic [23:0] GAIN_ZERO = 24'h000000;

	localparam int unsigned TBITS = lso_pkg::COS_TABLE_BITS;
	localparam int unsigned QUARTER_N = 1 << TBITS;
	localparam longint EST_MAX = 64'sd2147483647;
	localparam longint EST_MIN = -64'sd2147483648;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        gain_wen = 1'b0;
	logic [23:0] gain_wdata = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        command = 1'b0;
	logic [15:0] step_time = '0;
	logic [23:0] gap_deviation = '0;
	logic [15:0] heading_error = '0;
	logic [23:0] own_speed = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [22:0] leader_speed_estimate;

	// observer state as the block should hold it
	logic signed [23:0] gain_q = lso_pkg::GAIN_RESET;
	logic signed [31:0] est_q = '0;
	logic               tracking = 1'b0;

	logic [22:0] expected_speeds [$];
	logic [23:0] last_gap = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int gain_settings = 0;
	int zero_clamps = 0;
	int top_clamps = 0;
	int estimate_saturations = 0;

	leader_speed_observer i_dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.gain_wen              (gain_wen),
		.gain_wdata            (gain_wdata),
		.item_valid            (item_valid),
		.item_stall            (item_stall),
		.command               (command),
		.step_time             (step_time),
		.gap_deviation         (gap_deviation),
		.heading_error         (heading_error),
		.own_speed             (own_speed),
		.result_valid          (result_valid),
		.result_stall          (result_stall),
		.leader_speed_estimate (leader_speed_estimate)
	);

	always #4 clk = ~clk;

	// one horner stage in q30, floored at zero
	function automatic longint unsigned horner_term(input longint unsigned coef, p, u);
		longint unsigned t;
		t = (p * u) >> 30;
		return (coef > t) ? coef - t : 64'd0;
	endfunction

	// cos of k/N of a quarter turn in q16, taylor series up to the tenth power
	function automatic longint quarter_cos(input int unsigned k);
		longint unsigned q;
		longint unsigned u;
		longint unsigned p;
		q = 64'(k) << (16 - TBITS);
		u = (q * q) >> 2;
		p = 64'd27060;
		p = horner_term(64'd987048, p, u);
		p = horner_term(64'd22401992, p, u);
		p = horner_term(64'd272375560, p, u);
		p = horner_term(64'd1324675879, p, u);
		p = horner_term(64'd1073741824, p, u);
		return longint'((p + 64'd8192) >> 14);
	endfunction

	function automatic longint cos_turns(input logic [15:0] angle);
		int unsigned k;
		k = int'(angle[13:0]) >> (14 - TBITS);
		case (angle[15:14])
			2'd0: return quarter_cos(k);
			2'd1: return -quarter_cos(QUARTER_N - k);
			2'd2: return -quarter_cos(k);
			default: return quarter_cos(QUARTER_N - k);
		endcase
	endfunction

	// advances the observer state and gives the leader speed for one transaction
	function automatic logic [22:0] predict_leader_speed(input logic cmd,
			input logic [15:0] step, input logic [23:0] gap,
			input logic [15:0] heading, input logic [23:0] speed);
		longint err;
		longint corr;
		longint drive;
		longint leader;
		longint est;
		if (cmd == CMD_RESET) begin
			tracking = 1'b0;
			return '0;
		end
		if (!tracking) begin
			est_q = 32'($signed(gap));
			tracking = 1'b1;
			return '0;
		end
		err = longint'(est_q) - longint'($signed(gap));
		corr = (longint'(gain_q) * err + 64'sd32768) >>> 16;
		drive = (longint'($signed(speed)) * cos_turns(heading) + 64'sd32768) >>> 16;
		leader = corr + drive;
		est = longint'(est_q) + ((longint'(step) * corr + 64'sd32768) >>> 16);
		if (est > EST_MAX || est < EST_MIN) begin
			estimate_saturations++;
			est = (est > EST_MAX) ? EST_MAX : EST_MIN;
		end
		est_q = est[31:0];
		if (leader < 0) begin
			zero_clamps++;
			leader = 0;
		end
		if (leader > longint'(lso_pkg::OUT_MAX)) begin
			top_clamps++;
			leader = longint'(lso_pkg::OUT_MAX);
		end
		return leader[22:0];
	endfunction

	// present one transaction and wait for it to be taken
	task automatic send_item(input logic cmd, input logic [15:0] step,
			input logic [23:0] gap, input logic [15:0] heading, input logic [23:0] speed);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		command <= cmd;
		step_time <= step;
		gap_deviation <= gap;
		heading_error <= heading;
		own_speed <= speed;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		expected_speeds.push_back(predict_leader_speed(cmd, step, gap, heading, speed));
		items_sent++;
	endtask

	// only while idle: no transaction in flight
	task automatic write_gain(input logic [23:0] value);
		item_valid <= 1'b0;
		while (expected_speeds.size() != 0) @(posedge clk);
		gain_wen <= 1'b1;
		gain_wdata <= value;
		@(posedge clk);
		gain_wen <= 1'b0;
		gain_q = value;
		gain_settings++;
	endtask

	// mostly a gap that wanders slowly so the observer settles, with outliers
	task automatic send_random_item();
		logic cmd;
		logic [15:0] step;
		logic [15:0] heading;
		logic [23:0] gap;
		logic [23:0] speed;
		cmd = ($urandom_range(99) < 5) ? CMD_RESET : CMD_UPDATE;
		if ($urandom_range(99) < 70)
			gap = last_gap + 24'($urandom_range(65535)) - 24'd32768;
		else
			gap = 24'($urandom);
		step = ($urandom_range(99) < 70) ? 16'($urandom_range(6554)) : 16'($urandom);
		heading = 16'($urandom);
		speed = ($urandom_range(99) < 60) ? 24'($urandom_range(30 << 16)) : 24'($urandom);
		last_gap = gap;
		send_item(cmd, step, gap, heading, speed);
	endtask

	task automatic test_basic_updates();
		send_item(CMD_RESET, 16'h1234, 24'h123456, 16'h4321, 24'h0ABCDE);
		// first update after reset only latches the deviation
		send_item(CMD_UPDATE, 16'h0CCD, 24'h100000, 16'h0000, 24'h0A0000);
		send_item(CMD_UPDATE, 16'h0CCD, 24'h100000, 16'h0000, 24'h7FFFFF);
		send_item(CMD_UPDATE, 16'h0CCD, 24'h0F0000, 16'h2000, 24'h0A0000);
		send_item(CMD_UPDATE, 16'h0000, 24'h0F8000, 16'h4000, 24'h0A0000);
		send_item(CMD_UPDATE, 16'hFFFF, 24'h100000, 16'h8000, 24'h0A0000);
		send_item(CMD_UPDATE, 16'h0CCD, 24'h100000, 16'hC000, 24'h0A0000);
		send_item(CMD_UPDATE, 16'h0CCD, 24'h100000, 16'hFFFF, 24'h800000);
		send_item(CMD_UPDATE, 16'h0CCD, 24'h100000, 16'h8000, 24'h800000);
		send_item(CMD_UPDATE, 16'h0000, 24'h7FFFFF, 16'h0000, 24'h000000);
		send_item(CMD_UPDATE, 16'hFFFF, 24'h800000, 16'h0000, 24'h000000);
		send_item(CMD_UPDATE, 16'h0CCD, 24'h000000, 16'h3FFF, 24'h7FFFFF);
		send_item(CMD_RESET, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
		send_item(CMD_RESET, 16'h0000, 24'h000000, 16'h0000, 24'h000000);
		send_item(CMD_UPDATE, 16'hFFFF, 24'h800000, 16'h8001, 24'hFFFFFF);
		send_item(CMD_UPDATE, 16'h0CCD, 24'h7FFFFF, 16'h7FFF, 24'h123456);
		send_item(CMD_UPDATE, 16'h0CCD, 24'h7FFFFF, 16'h4000, 24'h654321);
	endtask

	task automatic test_gain_extremes();
		write_gain(GAIN_MAX);
		send_item(CMD_RESET, 16'h0000, 24'h000000, 16'h0000, 24'h000000);
		send_item(CMD_UPDATE, 16'hFFFF, 24'h7FFFFF, 16'h0000, 24'h010000);
		// a positive gain drives the estimate away until it saturates high
		repeat (3) send_item(CMD_UPDATE, 16'hFFFF, 24'h800000, 16'h0000, 24'h010000);
		write_gain(GAIN_MIN);
		repeat (3) send_item(CMD_UPDATE, 16'hFFFF, 24'h7FFFFF, 16'h8000, 24'h7FFFFF);
		write_gain(GAIN_ZERO);
		repeat (2) send_item(CMD_UPDATE, 16'h8000, 24'h000000, 16'h2000, 24'h050000);
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct,
			input int stall_pct, input logic [23:0] gain);
		write_gain(gain);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		send_item(CMD_RESET, 16'($urandom), 24'($urandom), 16'($urandom), 24'($urandom));
		repeat (count) send_random_item();
	endtask

	always @(posedge clk) begin : take_result
		logic [22:0] want;
		if (result_valid && !result_stall) begin
			if (expected_speeds.size() == 0) begin
				$error("unexpected result: leader_speed_estimate = %0d",
					leader_speed_estimate);
				error_count++;
			end else begin
				want = expected_speeds.pop_front();
				results_checked++;
				if (leader_speed_estimate !== want) begin
					$error("leader_speed_estimate: expected %0d, got %0d",
						want, leader_speed_estimate);
					error_count++;
				end
			end
		end
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		send_idle_pct = 22;
		recv_stall_pct = 87;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_updates();
		test_gain_extremes();
		test_random_traffic(375, 22, 87, 24'($urandom));
		test_random_traffic(375, 87, 22, 24'(32'd0 - $urandom_range(1, 1 << 18)));
		test_random_traffic(375, 0, 0, lso_pkg::GAIN_RESET);

		item_valid <= 1'b0;
		while (expected_speeds.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		$display("%0d transactions sent, %0d results checked under %0d gain settings",
			items_sent, results_checked, gain_settings);
		$display("leader speed clamped at zero %0d and at the top %0d times,",
			zero_clamps, top_clamps);
		$display("estimate saturated %0d times", estimate_saturations);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timed out with %0d results outstanding", expected_speeds.size());
		$display("FAIL");
		$finish;
	end

endmodule

// File: filelist.f
sv/lso_pkg.sv
sv/leader_speed_observer.sv
test/leader_speed_observer_tb.sv
